FILE: src/decimating_fir_filter_assert.svh
// Assertion macros used by the decimating FIR filter top level.
`ifndef DECIMATING_FIR_FILTER_ASSERT_SVH
`define DECIMATING_FIR_FILTER_ASSERT_SVH

// Checks a condition at every clock edge outside reset.
`define DFIR_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Checks that a condition seen at one edge is followed by another at the next edge.
`define DFIR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: src/dfir_pkg.sv
// Shared types and constants of the decimating FIR filter.
package dfir_pkg;

  localparam int SAMPLE_W    = 16;
  localparam int TAP_W       = 16;
  localparam int PROD_W      = 32;
  localparam int ACC_W       = 40;
  localparam int TAP_IDX_W   = 6;
  localparam int IN_DATA_W   = 40;
  localparam int OUT_DATA_W  = 40;

  localparam int CFG_AW      = 4;
  localparam int CFG_DW      = 32;
  localparam int TAP_COUNT_W = 7;
  localparam int DECIM_W     = 7;

  // Register indexes, taken from paddr[3:2].
  localparam logic [1:0] REG_TAP_COUNT  = 2'd0;
  localparam logic [1:0] REG_DECIMATION = 2'd1;
  localparam logic [1:0] REG_SAVE_STATE = 2'd2;

  // Item commands carried in tuser.
  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_TAP    = 1'b1;

  typedef struct packed {
    logic shift;   // take a new sample into the delay line
    logic rotate;  // circulate samples up and taps down by one cell
    logic clear;   // zero the sample held in every cell
  } cell_ctl_t;

  typedef struct packed {
    logic clear;    // start a new dot product
    logic prod_vld; // the current operands belong to the sum
  } mac_ctl_t;

endpackage

FILE: src/dfir_cell.sv
// One cell of the filter chain: holds one delay-line sample and one tap.
module dfir_cell
  import dfir_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  cell_ctl_t                  ctl,
  input  logic signed [SAMPLE_W-1:0] sample_in,
  input  logic signed [TAP_W-1:0]    tap_in,
  input  logic                       tap_we,
  input  logic signed [TAP_W-1:0]    tap_wdata,
  output logic signed [SAMPLE_W-1:0] sample_out,
  output logic signed [TAP_W-1:0]    tap_out
);

  logic signed [SAMPLE_W-1:0] sample_r, sample_nxt;
  logic signed [TAP_W-1:0]    tap_r, tap_nxt;

  always_comb begin
    sample_nxt = sample_r;
    if (ctl.clear) begin
      sample_nxt = '0;
    end else if (ctl.shift || ctl.rotate) begin
      sample_nxt = sample_in;
    end
    tap_nxt = tap_r;
    if (tap_we) begin
      tap_nxt = tap_wdata;
    end else if (ctl.rotate) begin
      tap_nxt = tap_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_r <= '0;
      tap_r    <= '0;
    end else begin
      sample_r <= sample_nxt;
      tap_r    <= tap_nxt;
    end
  end

  assign sample_out = sample_r;
  assign tap_out    = tap_r;

endmodule

FILE: src/dfir_mac.sv
// Multiply-accumulate unit fed with the tap of cell 0 and the oldest window sample of the cell chain.
module dfir_mac
  import dfir_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  mac_ctl_t                   ctl,
  input  logic signed [TAP_W-1:0]    tap,
  input  logic signed [SAMPLE_W-1:0] sample,
  output logic signed [ACC_W-1:0]    acc
);

  logic signed [PROD_W-1:0] prod_r, prod_nxt;
  logic                     pv_r, pv_nxt;
  logic signed [ACC_W-1:0]  acc_r, acc_nxt;

  always_comb begin
    // Both operands are sign-extended first so the product keeps its full width.
    prod_nxt = PROD_W'(tap) * PROD_W'(sample);
    pv_nxt   = ctl.prod_vld;
    acc_nxt  = acc_r;
    if (ctl.clear) begin
      acc_nxt = '0;
    end else if (pv_r) begin
      acc_nxt = acc_r + ACC_W'(prod_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= 1'b0;
    end else begin
      pv_r <= pv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    acc_r  <= acc_nxt;
  end

  assign acc = acc_r;

endmodule

FILE: src/decimating_fir_filter.sv
// Top level of the decimating FIR filter: control, configuration and the cell chain.
//
//  Channel | Ports        | Payload
//  in      | in_t*        | tdata: sample, tap_index, tap_value; tuser: command; tlast: block_end
//  out     | out_t*       | tdata: filtered_value
//  cfg     | cfg_p*       | tap_count @0x0, decimation @0x4, save_state @0x8
//
// Tap writes and samples that make no output are taken with the filter staying idle.
// A producing sample holds off input in MAC, DRAIN and DONE: the window and the taps
// circulate once around the MAX_TAPS cells past the single multiply-accumulate unit.
// The result waits in an output register; a further result stalls until it is taken.
// Reset (synchronous, active low) zeroes history, taps and phase and loads the
// register defaults.
`include "decimating_fir_filter_assert.svh"

module decimating_fir_filter
  import dfir_pkg::*;
#(
  parameter int MAX_TAPS       = 64,
  parameter int MAX_DECIMATION = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // sample[15:0], tap_index[21:16], tap_value[37:22]
  input  logic                  in_tuser,   // command
  input  logic                  in_tlast,   // block_end
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // filtered_value[39:0]
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_AW-1:0]     cfg_paddr,
  input  logic [CFG_DW-1:0]     cfg_pwdata,
  output logic [CFG_DW-1:0]     cfg_prdata,
  output logic                  cfg_pready
);

  localparam int TW = $clog2(MAX_TAPS);
  localparam int MW = $clog2(MAX_TAPS + 1);
  localparam int DW = $clog2(MAX_DECIMATION + 1);
  localparam int PW = (MAX_DECIMATION > 1) ? $clog2(MAX_DECIMATION) : 1;
  localparam logic [TW-1:0] CNT_LAST = TW'(MAX_TAPS - 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_MAC   = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  // Input fields.
  logic                       cmd;
  logic signed [SAMPLE_W-1:0] sample;
  logic [TAP_IDX_W-1:0]       tap_index;
  logic signed [TAP_W-1:0]    tap_value;
  logic                       block_end;

  assign sample    = in_tdata[15:0];
  assign tap_index = in_tdata[21:16];
  assign tap_value = in_tdata[37:22];
  assign cmd       = in_tuser;
  assign block_end = in_tlast;

  // Configuration registers.
  logic [TAP_COUNT_W-1:0] tap_count_r, tap_count_nxt;
  logic [DECIM_W-1:0]     decimation_r, decimation_nxt;
  logic                   save_state_r, save_state_nxt;
  logic                   cfg_wr;
  logic [1:0]             cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = cfg_paddr[3:2];

  always_comb begin
    tap_count_nxt  = tap_count_r;
    decimation_nxt = decimation_r;
    save_state_nxt = save_state_r;
    if (cfg_wr) begin
      case (cfg_idx)
        REG_TAP_COUNT:  tap_count_nxt  = cfg_pwdata[TAP_COUNT_W-1:0];
        REG_DECIMATION: decimation_nxt = cfg_pwdata[DECIM_W-1:0];
        REG_SAVE_STATE: save_state_nxt = cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_TAP_COUNT:  cfg_prdata = CFG_DW'(tap_count_r);
      REG_DECIMATION: cfg_prdata = CFG_DW'(decimation_r);
      REG_SAVE_STATE: cfg_prdata = CFG_DW'(save_state_r);
      default:        cfg_prdata = '0;
    endcase
  end

  // Effective tap count and decimation after clamping to their legal ranges.
  logic [MW-1:0] m_c;
  logic [DW-1:0] d_c;
  logic [TW-1:0] sel_idx;

  assign m_c = (tap_count_r == '0) ? MW'(1) :
               (32'(tap_count_r) > MAX_TAPS) ? MW'(MAX_TAPS) : MW'(tap_count_r);
  assign d_c = (decimation_r == '0) ? DW'(1) :
               (32'(decimation_r) > MAX_DECIMATION) ? DW'(MAX_DECIMATION) : DW'(decimation_r);
  // The oldest window sample sits in cell m-1.
  assign sel_idx = TW'(m_c - MW'(1));

  // Control.
  logic [1:0]    state_r, state_nxt;
  logic [TW-1:0] cnt_r, cnt_nxt;
  logic [PW-1:0] phase_r, phase_nxt;
  logic          clr_pend_r, clr_pend_nxt;
  logic          out_tvalid_r, out_tvalid_nxt;
  logic [ACC_W-1:0] out_data_r, out_data_nxt;

  logic          in_acc;
  logic          smp_acc;
  logic [PW-1:0] ph_eff;
  logic          produce;
  logic          slot_free;
  logic          tap_wr;
  cell_ctl_t     cell_ctl;
  mac_ctl_t      mac_ctl;
  logic signed [ACC_W-1:0] acc;

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign smp_acc   = in_acc && (cmd == CMD_SAMPLE);
  assign tap_wr    = in_acc && (cmd == CMD_TAP);
  assign slot_free = !out_tvalid_r || out_tready;

  // A phase left beyond a newly written decimation wraps to zero.
  assign ph_eff  = (32'(phase_r) >= 32'(d_c)) ? '0 : phase_r;
  assign produce = (ph_eff == '0);

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    phase_nxt      = phase_r;
    clr_pend_nxt   = clr_pend_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_data_nxt   = out_data_r;
    cell_ctl       = '0;
    mac_ctl        = '0;
    case (state_r)
      ST_IDLE: begin
        if (smp_acc) begin
          cell_ctl.shift = 1'b1;
          phase_nxt = (32'(ph_eff) + 1 >= 32'(d_c)) ? '0 : PW'(32'(ph_eff) + 1);
          if (block_end && !save_state_r) begin
            phase_nxt = '0;
          end
          if (produce) begin
            // History clearing waits until the window has been used.
            clr_pend_nxt  = block_end && !save_state_r;
            mac_ctl.clear = 1'b1;
            cnt_nxt       = '0;
            state_nxt     = ST_MAC;
          end else begin
            cell_ctl.clear = block_end && !save_state_r;
          end
        end
      end
      ST_MAC: begin
        cell_ctl.rotate  = 1'b1;
        mac_ctl.prod_vld = (MW'(cnt_r) < m_c);
        cnt_nxt          = cnt_r + TW'(1);
        if (cnt_r == CNT_LAST) begin
          cnt_nxt   = '0;
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (slot_free) begin
          out_tvalid_nxt = 1'b1;
          out_data_nxt   = acc;
          cell_ctl.clear = clr_pend_r;
          clr_pend_nxt   = 1'b0;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tap_count_r  <= TAP_COUNT_W'(64);
      decimation_r <= DECIM_W'(1);
      save_state_r <= 1'b1;
      state_r      <= ST_IDLE;
      cnt_r        <= '0;
      phase_r      <= '0;
      clr_pend_r   <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      tap_count_r  <= tap_count_nxt;
      decimation_r <= decimation_nxt;
      save_state_r <= save_state_nxt;
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      phase_r      <= phase_nxt;
      clr_pend_r   <= clr_pend_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = OUT_DATA_W'(out_data_r);

  // Cell chain: samples move toward higher cells, taps toward lower cells.
  logic signed [SAMPLE_W-1:0] sample_q [MAX_TAPS];
  logic signed [TAP_W-1:0]    tap_q    [MAX_TAPS];
  logic signed [SAMPLE_W-1:0] s_in     [MAX_TAPS];
  logic signed [TAP_W-1:0]    t_in     [MAX_TAPS];
  logic [MAX_TAPS-1:0]        cell_we;

  for (genvar i = 0; i < MAX_TAPS; i++) begin : g_cell
    assign s_in[i]    = (i == 0 && !cell_ctl.rotate) ? sample
                        : sample_q[(i == 0) ? MAX_TAPS - 1 : i - 1];
    assign t_in[i]    = tap_q[(i == MAX_TAPS - 1) ? 0 : i + 1];
    assign cell_we[i] = tap_wr && (32'(tap_index) == i);

    dfir_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (cell_ctl),
      .sample_in  (s_in[i]),
      .tap_in     (t_in[i]),
      .tap_we     (cell_we[i]),
      .tap_wdata  (tap_value),
      .sample_out (sample_q[i]),
      .tap_out    (tap_q[i])
    );
  end

  dfir_mac u_mac (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (mac_ctl),
    .tap    (tap_q[0]),
    .sample (sample_q[sel_idx]),
    .acc    (acc)
  );

  `DFIR_ASSERT_ALWAYS(a_no_clear_when_idle, !(state_r == ST_IDLE && clr_pend_r), "history clear left pending in idle")
  `DFIR_ASSERT_NEXT(a_mac_ends, state_r == ST_MAC && cnt_r == CNT_LAST, state_r == ST_DRAIN, "rotation did not end after a full turn")
  `DFIR_ASSERT_NEXT(a_phase_bound, smp_acc, 32'(phase_r) < 32'($past(d_c)), "phase not below decimation after a sample")
  `DFIR_ASSERT_NEXT(a_result_loaded, state_r == ST_DONE && slot_free, out_tvalid_r && state_r == ST_IDLE, "finished sum not delivered")

endmodule

FILE: tb/sv/decimating_fir_filter_checker.sv
// Predicts and checks the filter outputs by watching the input, output and register ports.
module decimating_fir_filter_checker
  import dfir_pkg::*;
#(
  parameter int MAX_TAPS       = 64,
  parameter int MAX_DECIMATION = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  in_tuser,
  input  logic                  in_tlast,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_AW-1:0]     cfg_paddr,
  input  logic [CFG_DW-1:0]     cfg_pwdata,
  input  logic                  cfg_pready,
  output int                    mismatch_count,
  output int                    pending,
  output int                    outputs_checked
);

  localparam int IDX_LSB  = SAMPLE_W;
  localparam int COEF_LSB = SAMPLE_W + TAP_IDX_W;

  logic [TAP_COUNT_W-1:0]     tap_count_reg;
  logic [DECIM_W-1:0]         decim_reg;
  logic                       save_reg;
  logic signed [TAP_W-1:0]    coef [MAX_TAPS];
  logic signed [SAMPLE_W-1:0] delay_line [MAX_TAPS-1];
  int                         decim_phase;
  logic [OUT_DATA_W-1:0]      expected_outputs [$];

  // A register value of zero acts as one, and values above the maximum saturate.
  function automatic int clamp_to(input int v, input int hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  // Tap 0 weighs the oldest sample of the window and tap m-1 the newest one.
  function automatic logic signed [ACC_W-1:0] dot_product(input logic signed [SAMPLE_W-1:0] x,
                                                          input int m);
    logic signed [ACC_W-1:0] acc;
    int j;
    acc = coef[m-1] * x;
    for (j = 0; j < m - 1; j++) begin
      acc = acc + coef[j] * delay_line[m-2-j];
    end
    return acc;
  endfunction

  task automatic clear_history();
    int k;
    for (k = 0; k < MAX_TAPS - 1; k++) begin
      delay_line[k] = '0;
    end
    decim_phase = 0;
  endtask

  task automatic take_item(input logic cmd, input logic [IN_DATA_W-1:0] data, input logic last);
    logic signed [SAMPLE_W-1:0] x;
    logic [TAP_IDX_W-1:0]       idx;
    int m;
    int d;
    int k;
    if (cmd == CMD_TAP) begin
      idx = data[IDX_LSB +: TAP_IDX_W];
      if (int'(idx) < MAX_TAPS) begin
        coef[idx] = data[COEF_LSB +: TAP_W];
      end
    end else begin
      x = data[SAMPLE_W-1:0];
      m = clamp_to(int'(tap_count_reg), MAX_TAPS);
      d = clamp_to(int'(decim_reg), MAX_DECIMATION);
      // A decimation lowered below the current phase wraps it here.
      if (decim_phase >= d) decim_phase = 0;
      if (decim_phase == 0) begin
        expected_outputs.push_back(dot_product(x, m));
      end
      decim_phase++;
      if (decim_phase >= d) decim_phase = 0;
      for (k = MAX_TAPS - 2; k > 0; k--) begin
        delay_line[k] = delay_line[k-1];
      end
      delay_line[0] = x;
      if (last && !save_reg) clear_history();
    end
  endtask

  task automatic check_output(input logic [OUT_DATA_W-1:0] actual);
    logic [OUT_DATA_W-1:0] want;
    if (expected_outputs.size() == 0) begin
      mismatch_count++;
      $display("%0t: output %0d arrived with no filter output expected", $time, $signed(actual));
    end else begin
      want = expected_outputs.pop_front();
      outputs_checked++;
      if (actual !== want) begin
        mismatch_count++;
        $display("%0t: filtered_value mismatch: expected %0d (0x%h), actual %0d (0x%h)",
                 $time, $signed(want), want, $signed(actual), actual);
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      tap_count_reg = TAP_COUNT_W'(MAX_TAPS);
      decim_reg     = DECIM_W'(1);
      save_reg      = 1'b1;
      for (int k = 0; k < MAX_TAPS; k++) begin
        coef[k] = '0;
      end
      clear_history();
      expected_outputs.delete();
      mismatch_count  = 0;
      outputs_checked = 0;
    end else begin
      if (out_tvalid && out_tready) check_output(out_tdata);
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr[3:2])
          REG_TAP_COUNT:  tap_count_reg = cfg_pwdata[TAP_COUNT_W-1:0];
          REG_DECIMATION: decim_reg     = cfg_pwdata[DECIM_W-1:0];
          REG_SAVE_STATE: save_reg      = cfg_pwdata[0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) take_item(in_tuser, in_tdata, in_tlast);
    end
    pending = expected_outputs.size();
  end

endmodule

FILE: tb/sv/decimating_fir_filter_tb.sv
// Top of the decimating FIR filter testbench: clock, reset, stimulus and verdict.
module decimating_fir_filter_tb;
  import dfir_pkg::*;

  localparam int MAX_TAPS       = 64;
  localparam int MAX_DECIMATION = 64;
  // Longer than one output computation.
  localparam int SETTLE_CYCLES  = 100;
  localparam int HOLD_CYCLES    = 600;
  localparam int STALL_LIMIT    = 5000;
  // An address past the last register; writes to it must change nothing.
  localparam logic [1:0] REG_UNUSED = 2'd3;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;   // sample[15:0], tap_index[21:16], tap_value[37:22]
  logic                  in_tuser = 1'b0; // command
  logic                  in_tlast = 1'b0; // block_end
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;       // filtered_value[39:0]
  logic                  cfg_psel = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite = 1'b0;
  logic [CFG_AW-1:0]     cfg_paddr = '0;
  logic [CFG_DW-1:0]     cfg_pwdata = '0;
  logic [CFG_DW-1:0]     cfg_prdata;
  logic                  cfg_pready;

  int mismatch_count;
  int pending;
  int outputs_checked;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_request = 1'b0;
  bit hold_done = 1'b0;
  int hold_left = 0;
  int stall_cycles = 0;
  int samples_sent = 0;
  int tap_writes_sent = 0;
  int settings_used = 1;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  decimating_fir_filter #(
    .MAX_TAPS       (MAX_TAPS),
    .MAX_DECIMATION (MAX_DECIMATION)
  ) i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  decimating_fir_filter_checker #(
    .MAX_TAPS       (MAX_TAPS),
    .MAX_DECIMATION (MAX_DECIMATION)
  ) i_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .in_tuser        (in_tuser),
    .in_tlast        (in_tlast),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .cfg_psel        (cfg_psel),
    .cfg_penable     (cfg_penable),
    .cfg_pwrite      (cfg_pwrite),
    .cfg_paddr       (cfg_paddr),
    .cfg_pwdata      (cfg_pwdata),
    .cfg_pready      (cfg_pready),
    .mismatch_count  (mismatch_count),
    .pending         (pending),
    .outputs_checked (outputs_checked)
  );

  // Result side: random stalls, plus one long hold-off that backs the filter up.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_tready <= 1'b0;
    end else if (hold_request && !hold_done) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
          (cfg_psel && cfg_penable && cfg_pready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles = stall_cycles + 1;
      end
      if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
        $display("decimating_fir_filter test failed");
        $finish;
      end
    end
  end

  function automatic logic [15:0] pick16();
    case ($urandom_range(9))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      2:       return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_item(input logic cmd, input logic [15:0] smp, input logic [5:0] idx,
                           input logic [15:0] tap, input logic last);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tlast  <= last;
    in_tdata  <= {2'b00, tap, idx, smp};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (cmd == CMD_TAP) tap_writes_sent++;
    else samples_sent++;
  endtask

  task automatic send_random_items(input int count);
    int   k;
    logic cmd;
    for (k = 0; k < count; k++) begin
      cmd = ($urandom_range(99) < 12) ? CMD_TAP : CMD_SAMPLE;
      send_item(cmd, pick16(), 6'($urandom), pick16(), ($urandom_range(99) < 8));
    end
  endtask

  // Waits until every expected output has been taken and the filter has gone quiet.
  task automatic drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [CFG_DW-1:0] value);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  task automatic configure(input int taps_in_use, input int decim, input int save);
    drain();
    write_reg(REG_TAP_COUNT, taps_in_use);
    write_reg(REG_DECIMATION, decim);
    write_reg(REG_SAVE_STATE, save);
    settings_used++;
  endtask

  initial begin
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 32;
    recv_idle_pct = 51;

    // Reset settings: 64 taps, every sample gives an output, history kept.
    send_item(CMD_TAP,    16'h0000, 6'd0,  16'h8000, 1'b1);
    send_item(CMD_TAP,    16'hffff, 6'd63, 16'h7fff, 1'b0);
    send_item(CMD_TAP,    16'h1234, 6'd62, 16'h8000, 1'b0);
    send_item(CMD_SAMPLE, 16'h7fff, 6'd0,  16'h0000, 1'b0);
    send_item(CMD_SAMPLE, 16'h8000, 6'd63, 16'hffff, 1'b0);
    send_item(CMD_SAMPLE, 16'h8000, 6'd0,  16'h0000, 1'b0);
    send_item(CMD_SAMPLE, 16'h0001, 6'd0,  16'h0000, 1'b1);
    send_item(CMD_SAMPLE, 16'hffff, 6'd0,  16'h0000, 1'b0);

    // Zero tap count and zero decimation act as one; block ends clear history.
    configure(0, 0, 0);
    write_reg(REG_UNUSED, 32'h5a);
    send_item(CMD_SAMPLE, 16'h8000, 6'd0, 16'h0000, 1'b0);
    send_item(CMD_SAMPLE, 16'h7fff, 6'd0, 16'h0000, 1'b1);
    send_item(CMD_TAP,    16'h0000, 6'd0, 16'h7fff, 1'b0);
    send_item(CMD_SAMPLE, 16'h8000, 6'd0, 16'h0000, 1'b0);
    configure(3, 2, 0);
    send_item(CMD_TAP,    16'h0000, 6'd2, 16'h4000, 1'b0);
    send_item(CMD_SAMPLE, 16'h7fff, 6'd0, 16'h0000, 1'b0);
    send_item(CMD_SAMPLE, 16'h0100, 6'd0, 16'h0000, 1'b1);
    send_item(CMD_SAMPLE, 16'h8000, 6'd0, 16'h0000, 1'b0);
    send_item(CMD_SAMPLE, 16'h0003, 6'd0, 16'h0000, 1'b0);

    configure(64, 1, 1);
    send_random_items(30);
    hold_request = 1'b1;
    send_random_items(220);
    // Both registers above their maximum saturate.
    configure(127, 127, 0);
    send_random_items(250);

    send_idle_pct = 51;
    recv_idle_pct = 32;
    configure(1, 64, 1);
    send_random_items(200);
    // The phase carried over from the long decimation may exceed the new one.
    configure(17, 3, 0);
    send_random_items(250);
    configure($urandom_range(64, 1), $urandom_range(8, 1), $urandom_range(1));
    send_random_items(250);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    configure(64, 2, 0);
    send_random_items(250);
    configure($urandom_range(127), $urandom_range(10), $urandom_range(1));
    send_random_items(250);

    drain();
    $display("Sent %0d samples and %0d tap writes under %0d register settings.",
             samples_sent, tap_writes_sent, settings_used);
    $display("Checked %0d filter outputs, including a %0d-cycle output stall.",
             outputs_checked, HOLD_CYCLES);
    if (mismatch_count == 0 && pending == 0) begin
      $display("decimating_fir_filter test passed");
    end else begin
      $display("decimating_fir_filter test failed");
    end
    $finish;
  end

endmodule
